@@ sv/ptrl_pkg.sv @@
package ptrl_pkg;

  localparam int unsigned PEER_SLOTS_DEF = 16;
  localparam logic [31:0] DEF_LIMIT_RST = 32'd100;
  localparam logic [31:0] WINDOW_RST = 32'd1000;
  localparam int unsigned FQ_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_LOOKUP  = 3'd2,
    CMD_RATE    = 3'd3,
    CMD_SET_LIM = 3'd4,
    CMD_SET_VER = 3'd5,
    CMD_HOST    = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_LIMITED   = 2'd3
  } status_t;

  typedef enum logic {
    REG_DEF_LIMIT = 1'b0,
    REG_WINDOW    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] user_id;
    logic               host_flag_in;
    logic [31:0]        value_in;
    logic [31:0]        now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot_out;
    logic signed [31:0] found_user;
    logic               found_is_host;
    logic [31:0]        found_version;
    logic [31:0]        found_limit;
    logic [4:0]         peer_count;
  } out_word_t;

endpackage

@@ sv/ptrl_front.sv @@
module ptrl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ptrl_pkg::in_word_t in_word,
  output logic               q_valid,
  input  logic               q_take,
  output ptrl_pkg::in_word_t q_word
);
  import ptrl_pkg::*;

  localparam int unsigned PW = $clog2(FQ_DEPTH);

  in_word_t       mem_r [FQ_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;

  assign in_full = (cnt_r == (PW+1)'(FQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_word  = mem_r[rp_r];

  wire do_push = in_push && !in_full;
  wire do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(FQ_DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PW'(FQ_DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end
endmodule

@@ sv/ptrl_back.sv @@
module ptrl_back #(
  parameter int unsigned PEER_SLOTS = ptrl_pkg::PEER_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         def_limit,
  input  logic [31:0]         window_ms,
  input  logic                q_valid,
  output logic                q_take,
  input  ptrl_pkg::in_word_t  q_word,
  output logic                out_empty,
  input  logic                out_pop,
  output ptrl_pkg::out_word_t out_word
);
  import ptrl_pkg::*;

  localparam int unsigned SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(PEER_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r;

  logic [PEER_SLOTS-1:0] act_r, host_r;
  logic [31:0] user_r [PEER_SLOTS];
  logic [31:0] ver_r  [PEER_SLOTS];
  logic [31:0] lim_r  [PEER_SLOTS];
  logic [31:0] win_r  [PEER_SLOTS];
  logic [31:0] msg_r  [PEER_SLOTS];
  logic        ready_r;

  in_word_t  w_r;
  logic      hit_r, free_ok_r, host_ok_r;
  logic [SW-1:0] hit_s_r, free_s_r, host_s_r;
  out_word_t hold_r;
  out_word_t res_r;
  logic      res_v_r;

  logic            hit, free_ok, host_ok;
  logic [SW-1:0]   hit_s, free_s, host_s;

  always_comb begin
    hit = 1'b0; free_ok = 1'b0; host_ok = 1'b0;
    hit_s = '0; free_s = '0; host_s = '0;
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (act_r[i] && user_r[i] == w_r.user_id) begin
        hit = 1'b1; hit_s = SW'(i);
      end
      if (!act_r[i]) begin
        free_ok = 1'b1; free_s = SW'(i);
      end
      if (act_r[i] && host_r[i]) begin
        host_ok = 1'b1; host_s = SW'(i);
      end
    end
  end

  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign out_empty = !res_v_r;
  assign out_word  = res_r;

  logic [SW-1:0] s;
  logic [31:0]   elapsed;
  logic          rep;
  logic [1:0]    st;
  logic [PEER_SLOTS-1:0] act_n;

  always_comb begin
    s = hit_s;
    rep = 1'b0;
    st = ST_OK;
    unique case (cmd_t'(w_r.cmd))
      CMD_ADD: begin
        if (hit_r) rep = 1'b1;
        else if (free_ok_r) begin s = free_s_r; rep = 1'b1; end
        else st = ST_FULL;
      end
      CMD_HOST: begin
        s = host_s_r;
        if (host_ok_r) rep = 1'b1; else st = ST_NOT_FOUND;
      end
      CMD_CLEAR: st = ST_OK;
      default: begin
        if (hit_r) rep = 1'b1; else st = ST_NOT_FOUND;
      end
    endcase
    if (cmd_t'(w_r.cmd) == CMD_ADD) s = hit_r ? hit_s_r : free_s_r;
    else if (cmd_t'(w_r.cmd) != CMD_HOST) s = hit_s_r;
    elapsed = w_r.now_ms - win_r[s];
    if (cmd_t'(w_r.cmd) == CMD_RATE && hit_r && lim_r[s] != '0 &&
        elapsed < window_ms && msg_r[s] >= lim_r[s]) st = ST_LIMITED;
    act_n = act_r;
    if (cmd_t'(w_r.cmd) == CMD_CLEAR) act_n = '0;
    else if (cmd_t'(w_r.cmd) == CMD_REMOVE && hit_r) act_n[s] = 1'b0;
    else if (cmd_t'(w_r.cmd) == CMD_ADD && !hit_r && free_ok_r) act_n[s] = 1'b1;
  end

  logic [CW-1:0] pc;
  always_comb begin
    pc = '0;
    for (int i = 0; i < PEER_SLOTS; i++) pc = pc + CW'(act_n[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_v_r <= 1'b0;
      ready_r <= 1'b1;
      act_r   <= PEER_SLOTS'(1);
      host_r  <= PEER_SLOTS'(1);
      for (int i = 0; i < PEER_SLOTS; i++) begin
        user_r[i] <= (i == 0) ? 32'd1 : 32'd0;
        ver_r[i]  <= '0;
        lim_r[i]  <= (i == 0) ? DEF_LIMIT_RST : 32'd0;
        win_r[i]  <= '0;
        msg_r[i]  <= '0;
      end
    end else begin
      if (out_pop && res_v_r && state_r != S_OUT) res_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            w_r <= q_word;
            if (!ready_r && cmd_t'(q_word.cmd) != CMD_REMOVE &&
                cmd_t'(q_word.cmd) != CMD_CLEAR) begin
              ready_r <= 1'b1;
              act_r   <= PEER_SLOTS'(1);
              host_r  <= PEER_SLOTS'(1);
              for (int i = 0; i < PEER_SLOTS; i++) begin
                user_r[i] <= (i == 0) ? 32'd1 : 32'd0;
                ver_r[i]  <= '0;
                lim_r[i]  <= (i == 0) ? def_limit : 32'd0;
                win_r[i]  <= (i == 0) ? q_word.now_ms : 32'd0;
                msg_r[i]  <= '0;
              end
            end
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          hit_r <= hit; hit_s_r <= hit_s;
          free_ok_r <= free_ok; free_s_r <= free_s;
          host_ok_r <= host_ok; host_s_r <= host_s;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          hold_r.status        <= st;
          hold_r.slot_out      <= rep ? 4'(s) : '0;
          hold_r.found_is_host <= rep ? ((cmd_t'(w_r.cmd) == CMD_ADD) ?
                                  w_r.host_flag_in : host_r[s]) : 1'b0;
          hold_r.found_user    <= rep ? ((cmd_t'(w_r.cmd) == CMD_ADD && !hit_r) ?
                                  w_r.user_id : user_r[s]) : '0;
          hold_r.found_version <= (rep && !(cmd_t'(w_r.cmd) == CMD_ADD && !hit_r)) ?
                                  ((cmd_t'(w_r.cmd) == CMD_SET_VER) ? w_r.value_in
                                  : ver_r[s]) : '0;
          hold_r.found_limit   <= rep ? ((cmd_t'(w_r.cmd) == CMD_ADD && !hit_r) ?
                                  def_limit : (cmd_t'(w_r.cmd) == CMD_SET_LIM) ?
                                  w_r.value_in : lim_r[s]) : '0;
          hold_r.peer_count    <= 5'(pc);
          act_r   <= act_n;
          case (cmd_t'(w_r.cmd))
            CMD_ADD: begin
              if (rep) host_r[s] <= w_r.host_flag_in;
              if (!hit_r && free_ok_r) begin
                user_r[s] <= w_r.user_id; ver_r[s] <= '0; lim_r[s] <= def_limit;
                win_r[s] <= w_r.now_ms; msg_r[s] <= '0;
              end
            end
            CMD_REMOVE: if (hit_r) begin
              host_r[s] <= 1'b0; user_r[s] <= '0; ver_r[s] <= '0;
              lim_r[s] <= '0; win_r[s] <= '0; msg_r[s] <= '0;
            end
            CMD_SET_LIM: if (hit_r) lim_r[s] <= w_r.value_in;
            CMD_SET_VER: if (hit_r) ver_r[s] <= w_r.value_in;
            CMD_RATE: if (hit_r && lim_r[s] != '0) begin
              if (elapsed >= window_ms) begin
                win_r[s] <= w_r.now_ms; msg_r[s] <= 32'd1;
              end else if (msg_r[s] < lim_r[s]) msg_r[s] <= msg_r[s] + 32'd1;
            end
            CMD_CLEAR: begin
              ready_r <= 1'b0;
              host_r  <= '0;
              for (int i = 0; i < PEER_SLOTS; i++) begin
                user_r[i] <= '0; ver_r[i] <= '0; lim_r[i] <= '0;
                win_r[i] <= '0; msg_r[i] <= '0;
              end
            end
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!res_v_r || out_pop) begin
            res_r   <= hold_r;
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/peer_table_rate_limiter.sv @@
// channel | ports                          | handshake
// input   | in_push in_full in_word        | push && !full
// result  | out_empty out_pop out_word     | pop && !empty
// config  | cfg_valid cfg_ready cfg_index  | valid && ready
//
// An item passes through the table sequencer's steps in order: take, match, update, publish.
// Two-entry input queue lets pushes land while the sequencer works.
// Publish waits only when the result register is still full and not popped.
// Synchronous active-low reset reinstalls host peer 1 in slot 0.
module peer_table_rate_limiter #(
  parameter int unsigned PEER_SLOTS = ptrl_pkg::PEER_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ptrl_pkg::in_word_t  in_word,
  output logic                out_empty,
  input  logic                out_pop,
  output ptrl_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import ptrl_pkg::*;

  logic [31:0] def_limit_r, window_r;
  logic        q_valid, q_take;
  in_word_t    q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_limit_r <= DEF_LIMIT_RST;
      window_r    <= WINDOW_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEF_LIMIT: def_limit_r <= cfg_data;
        REG_WINDOW:    window_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  ptrl_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_word,
    .q_valid, .q_take, .q_word
  );

  ptrl_back #(.PEER_SLOTS(PEER_SLOTS)) u_back (
    .clk, .rst_n, .def_limit(def_limit_r), .window_ms(window_r),
    .q_valid, .q_take, .q_word, .out_empty, .out_pop, .out_word
  );

`ifndef SYNTHESIS
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word))) else $error("word lost");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_word.peer_count <= 5'(PEER_SLOTS)) else $error("count");
`endif
endmodule
